### design/qrs_pkg.sv
// shared constants and types of the quadratic root solver
package qrs_pkg;

    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ROOT_WIDTH     = 40;
    localparam int STATUS_WIDTH   = 2;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_NOT_QUAD = 2'd0,
        ST_NO_REAL  = 2'd1,
        ST_SINGLE   = 2'd2,
        ST_TWO      = 2'd3
    } t_status;

    localparam logic [63:0] ROOT_POS_MAX = (64'd1 << (ROOT_WIDTH - 1)) - 64'd1;
    localparam logic [63:0] ROOT_NEG_MAX = 64'd1 << (ROOT_WIDTH - 1);

endpackage

### design/qrs_isqrt.sv
// pipelined integer square root, one root bit per stage
module qrs_isqrt #(
    parameter int DW     = 34,
    parameter int SIDE_W = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [DW-1:0]       i_radicand,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic [DW/2-1:0]     o_root,
    output logic [SIDE_W-1:0]   o_side
);
    localparam int N = DW / 2;

    logic              r_v    [0:N-1];
    logic [DW-1:0]     r_rem  [0:N-1];
    logic [DW-1:0]     r_d    [0:N-1];
    logic [N-1:0]      r_root [0:N-1];
    logic [SIDE_W-1:0] r_side [0:N-1];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic              v_in;
        logic [DW-1:0]     rem_in;
        logic [DW-1:0]     d_in;
        logic [N-1:0]      root_in;
        logic [SIDE_W-1:0] side_in;
        logic [DW-1:0]     cand;
        logic [DW-1:0]     trial;
        logic              ge;
        logic [DW-1:0]     n_rem;
        logic [N-1:0]      n_root;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign d_in    = i_radicand;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign d_in    = r_d[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
        end

        // bring down the next bit pair and try subtracting 4*root+1
        assign cand   = {rem_in[DW-3:0], d_in[DW-1 -: 2]};
        assign trial  = DW'({root_in, 2'b01});
        assign ge     = (cand >= trial);
        assign n_rem  = ge ? (cand - trial) : cand;
        assign n_root = {root_in[N-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_d[k]    <= d_in << 2;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

### design/qrs_div.sv
// pipelined twin restoring divider sharing one divisor, one quotient bit per stage
module qrs_div #(
    parameter int NW     = 34,
    parameter int DVW    = 18,
    parameter int SIDE_W = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [NW-1:0]       i_num_p,
    input  logic [NW-1:0]       i_num_m,
    input  logic [DVW-1:0]      i_den,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic [NW-1:0]       o_quot_p,
    output logic [NW-1:0]       o_quot_m,
    output logic [SIDE_W-1:0]   o_side
);
    logic              r_v     [0:NW-1];
    logic [DVW-1:0]    r_rem_p [0:NW-1];
    logic [DVW-1:0]    r_rem_m [0:NW-1];
    logic [NW-1:0]     r_n_p   [0:NW-1];
    logic [NW-1:0]     r_n_m   [0:NW-1];
    logic [NW-1:0]     r_q_p   [0:NW-1];
    logic [NW-1:0]     r_q_m   [0:NW-1];
    logic [DVW-1:0]    r_den   [0:NW-1];
    logic [SIDE_W-1:0] r_side  [0:NW-1];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic              v_in;
        logic [DVW-1:0]    rp_in, rm_in, den_in;
        logic [NW-1:0]     np_in, nm_in, qp_in, qm_in;
        logic [SIDE_W-1:0] side_in;
        logic [DVW:0]      cand_p, cand_m;
        logic              ge_p, ge_m;
        logic [DVW:0]      n_rem_p, n_rem_m;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rp_in   = '0;
            assign rm_in   = '0;
            assign np_in   = i_num_p;
            assign nm_in   = i_num_m;
            assign qp_in   = '0;
            assign qm_in   = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rp_in   = r_rem_p[k-1];
            assign rm_in   = r_rem_m[k-1];
            assign np_in   = r_n_p[k-1];
            assign nm_in   = r_n_m[k-1];
            assign qp_in   = r_q_p[k-1];
            assign qm_in   = r_q_m[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
        end

        assign cand_p  = {rp_in, np_in[NW-1]};
        assign cand_m  = {rm_in, nm_in[NW-1]};
        assign ge_p    = (cand_p >= {1'b0, den_in});
        assign ge_m    = (cand_m >= {1'b0, den_in});
        assign n_rem_p = ge_p ? (cand_p - {1'b0, den_in}) : cand_p;
        assign n_rem_m = ge_m ? (cand_m - {1'b0, den_in}) : cand_m;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
            if (i_en) begin
                // remainder stays below the divisor
                r_rem_p[k] <= n_rem_p[DVW-1:0];
                r_rem_m[k] <= n_rem_m[DVW-1:0];
                r_n_p[k]   <= np_in << 1;
                r_n_m[k]   <= nm_in << 1;
                r_q_p[k]   <= {qp_in[NW-2:0], ge_p};
                r_q_m[k]   <= {qm_in[NW-2:0], ge_m};
                r_den[k]   <= den_in;
                r_side[k]  <= side_in;
            end
        end
    end

    assign o_valid  = r_v[NW-1];
    assign o_quot_p = r_q_p[NW-1];
    assign o_quot_m = r_q_m[NW-1];
    assign o_side   = r_side[NW-1];

endmodule

### design/quadratic_root_solver.sv
// top level of the quadratic root solver
//
// real roots of a*x^2 + b*x + c for one coefficient set per transaction
// slave channel: i_s_tdata carries a, b, c (COEF_WIDTH bits each, two's complement)
// master channel: o_m_tuser carries the status (not quadratic, no real root,
//   single root, two roots), o_m_tdata carries root_plus then root_minus,
//   both signed with FRAC_BITS fraction bits, saturated to 40 bits
// pipeline: input stage, two multipliers, discriminant and classify,
//   COEF_WIDTH+1 square root stages (one root bit each), numerator stage,
//   COEF_WIDTH+2+FRAC_BITS divider stages (one quotient bit each, both
//   roots in parallel), output register
// throughput: one transaction per cycle while the master side takes results, no state between transactions
// the divider length sets the depth; every stage carries its own valid bit
// a stall at the master side freezes the whole pipeline in place: o_s_tready
//   drops only while a result waits in the output register and is not taken
// reset clears all valid bits; payload registers keep their contents
module quadratic_root_solver #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_s_tvalid,
    output logic                                      o_s_tready,
    // coef_a, coef_b, coef_c from the lowest bit up, zero padding on top
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]         i_s_tdata,
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready,
    // root_plus, root_minus from the lowest bit up
    output logic [2*qrs_pkg::ROOT_WIDTH-1:0]          o_m_tdata,
    // root_status
    output logic [qrs_pkg::STATUS_WIDTH-1:0]          o_m_tuser
);
    import qrs_pkg::*;

    localparam int W      = COEF_WIDTH;
    localparam int DW     = 2 * W + 2;          // discriminant width
    localparam int SW     = W + 1;              // square root width
    localparam int MW     = W + 2;              // numerator magnitude width
    localparam int QW     = MW + FRAC_BITS;     // dividend and quotient width
    localparam int SQ_SW  = STATUS_WIDTH + (W + 1) + W + 1;
    localparam int DV_SW  = STATUS_WIDTH + 2;

    logic en;
    assign en = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // stage 1: split the coefficients into sign and magnitude, flag zero a and c, negate b
    logic signed [W-1:0] a_in, b_in, c_in;
    assign a_in = i_s_tdata[W-1:0];
    assign b_in = i_s_tdata[2*W-1:W];
    assign c_in = i_s_tdata[3*W-1:2*W];

    logic            r1_v;
    logic [W-1:0]    r1_ma, r1_mb, r1_mc;
    logic            r1_sa, r1_sc, r1_az, r1_cz;
    logic [W:0]      r1_nb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_tvalid;
        end
        if (en) begin
            r1_ma <= a_in[W-1] ? W'(-a_in) : W'(a_in);
            r1_mb <= b_in[W-1] ? W'(-b_in) : W'(b_in);
            r1_mc <= c_in[W-1] ? W'(-c_in) : W'(c_in);
            r1_sa <= a_in[W-1];
            r1_sc <= c_in[W-1];
            r1_az <= (a_in == '0);
            r1_cz <= (c_in == '0);
            r1_nb <= -{b_in[W-1], b_in};
        end
    end

    // stage 2: b^2 and |a*c|
    logic            r2_v;
    logic [2*W-1:0]  r2_bsq, r2_prod;
    logic [W-1:0]    r2_ma;
    logic            r2_sa, r2_az, r2_add;
    logic [W:0]      r2_nb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            r2_bsq  <= (2*W)'(r1_mb) * (2*W)'(r1_mb);
            r2_prod <= (2*W)'(r1_ma) * (2*W)'(r1_mc);
            r2_ma   <= r1_ma;
            r2_sa   <= r1_sa;
            r2_az   <= r1_az;
            // opposite signs of a and c make 4ac add to b^2
            r2_add  <= (r1_sa != r1_sc) && !r1_cz;
            r2_nb   <= r1_nb;
        end
    end

    // stage 3: discriminant and classification
    logic [DW-1:0] q4, bsq_x, delta;
    logic          neg_disc;
    t_status       status3;

    assign q4       = {r2_prod, 2'b00};
    assign bsq_x    = DW'(r2_bsq);
    assign neg_disc = !r2_add && (q4 > bsq_x);
    assign delta    = r2_add ? (bsq_x + q4) : (bsq_x - q4);

    always_comb begin
        if (r2_az) begin
            status3 = ST_NOT_QUAD;
        end else if (neg_disc) begin
            status3 = ST_NO_REAL;
        end else if (delta == '0) begin
            status3 = ST_SINGLE;
        end else begin
            status3 = ST_TWO;
        end
    end

    logic              r3_v;
    logic [DW-1:0]     r3_delta;
    logic [SQ_SW-1:0]  r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
        if (en) begin
            r3_delta <= delta;
            r3_side  <= {status3, r2_nb, r2_ma, r2_sa};
        end
    end

    // square root pipeline
    logic              sq_v;
    logic [SW-1:0]     sq_root;
    logic [SQ_SW-1:0]  sq_side;

    qrs_isqrt #(
        .DW     (DW),
        .SIDE_W (SQ_SW)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r3_v),
        .i_radicand (r3_delta),
        .i_side     (r3_side),
        .o_valid    (sq_v),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    // numerator stage: -b +/- sqrt, split into sign and magnitude
    t_status        sq_status;
    logic [W:0]     sq_nb;
    logic [W-1:0]   sq_ma;
    logic           sq_sa;
    logic [W+2:0]   num_p, num_m;
    logic [MW-1:0]  mag_p, mag_m;

    assign sq_status = t_status'(sq_side[SQ_SW-1 -: STATUS_WIDTH]);
    assign sq_nb     = sq_side[2*W+1:W+1];
    assign sq_ma     = sq_side[W:1];
    assign sq_sa     = sq_side[0];
    assign num_p     = {{2{sq_nb[W]}}, sq_nb} + {2'b00, sq_root};
    assign num_m     = {{2{sq_nb[W]}}, sq_nb} - {2'b00, sq_root};
    assign mag_p     = num_p[W+2] ? MW'(-num_p) : MW'(num_p);
    assign mag_m     = num_m[W+2] ? MW'(-num_m) : MW'(num_m);

    logic              r4_v;
    logic [QW-1:0]     r4_np, r4_nm;
    logic [MW-1:0]     r4_den;
    logic [DV_SW-1:0]  r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= sq_v;
        end
        if (en) begin
            r4_np   <= QW'(mag_p) << FRAC_BITS;
            r4_nm   <= QW'(mag_m) << FRAC_BITS;
            r4_den  <= {1'b0, sq_ma, 1'b0};
            r4_side <= {sq_status, num_p[W+2] != sq_sa, num_m[W+2] != sq_sa};
        end
    end

    // division pipeline
    logic              dv_v;
    logic [QW-1:0]     dv_qp, dv_qm;
    logic [DV_SW-1:0]  dv_side;

    qrs_div #(
        .NW     (QW),
        .DVW    (MW),
        .SIDE_W (DV_SW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r4_v),
        .i_num_p  (r4_np),
        .i_num_m  (r4_nm),
        .i_den    (r4_den),
        .i_side   (r4_side),
        .o_valid  (dv_v),
        .o_quot_p (dv_qp),
        .o_quot_m (dv_qm),
        .o_side   (dv_side)
    );

    // output stage: sign, saturation and masking by status
    function automatic logic [ROOT_WIDTH-1:0] sat_root(input logic [63:0] q,
                                                       input logic neg);
        logic [63:0] qc;
        if (neg && (q != '0)) begin
            qc = (q > ROOT_NEG_MAX) ? ROOT_NEG_MAX : q;
            sat_root = ROOT_WIDTH'(-qc);
        end else begin
            qc = (q > ROOT_POS_MAX) ? ROOT_POS_MAX : q;
            sat_root = qc[ROOT_WIDTH-1:0];
        end
    endfunction

    t_status                dv_status;
    logic [ROOT_WIDTH-1:0]  root_p, root_m;

    assign dv_status = t_status'(dv_side[DV_SW-1 -: STATUS_WIDTH]);
    assign root_p    = sat_root(64'(dv_qp), dv_side[1]);
    assign root_m    = sat_root(64'(dv_qm), dv_side[0]);

    logic                   r_out_v;
    t_status                r_out_status;
    logic [ROOT_WIDTH-1:0]  r_out_p, r_out_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= dv_v;
        end
        if (en) begin
            r_out_status <= dv_status;
            r_out_p      <= (dv_status == ST_SINGLE || dv_status == ST_TWO) ? root_p : '0;
            r_out_m      <= (dv_status == ST_TWO) ? root_m : '0;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {r_out_m, r_out_p};
    assign o_m_tuser  = r_out_status;

    // no roots reported without a real solution
    a_no_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_NOT_QUAD || o_m_tuser == ST_NO_REAL)
        |-> (r_out_p == '0) && (r_out_m == '0))
        else $error("root given without a real solution");

    // second root only for two distinct roots
    a_minus_only_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ST_TWO) |-> (r_out_m == '0))
        else $error("second root given without two roots");

    // a stalled pipeline keeps its output transaction
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> r_out_v && $stable(r_out_p) && $stable(r_out_m))
        else $error("output changed during stall");

endmodule

### tb/sv/quadratic_root_solver_tb.sv
// self-checking testbench of the quadratic root solver, randomised stream traffic
`timescale 1ns / 1ps

module quadratic_root_solver_tb;
    import qrs_pkg::*;

    localparam int CW       = 16;
    localparam int FB       = 16;
    localparam int IN_W     = ((3*CW+7)/8)*8;
    localparam int N_RANDOM = 1700;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
    } t_coefs;

    typedef struct packed {
        t_status     status;
        logic [39:0] plus;
        logic [39:0] minus;
    } t_roots;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [IN_W-1:0]   i_s_tdata = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [79:0]       o_m_tdata;
    logic [1:0]        o_m_tuser;

    t_coefs pending_sets[$];
    t_roots expected_roots[$];
    int     n_errors = 0;
    int     n_sent = 0;
    int     n_got = 0;
    int     idle_cycles = 0;
    int     status_seen[4] = '{0, 0, 0, 0};
    bit     stim_done = 1'b0;
    bit     calm = 1'b0;        // no idling on either side
    bit     hold_off = 1'b0;    // long receiver stall requested
    int     hold_cnt = 0;

    quadratic_root_solver #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // coef_a, coef_b, coef_c from bit 0 up
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // root_plus, root_minus from bit 0 up
        .o_m_tuser  (o_m_tuser)    // root_status
    );

    always #5 i_clk = ~i_clk;

    // trunc(num * 2^FB / 2a), saturated to the 40-bit root range
    function automatic logic [39:0] fixed_div(longint num, longint a);
        logic [127:0] mag;
        logic [127:0] den;
        logic [127:0] q;
        bit           neg;
        mag = 128'(num < 0 ? -num : num) << FB;
        den = 128'(a < 0 ? -a : a) << 1;
        q   = mag / den;
        neg = ((num < 0) != (a < 0)) && q != 0;
        if (neg) begin
            if (q > 128'(ROOT_NEG_MAX)) q = 128'(ROOT_NEG_MAX);
            return 40'(-q);
        end
        if (q > 128'(ROOT_POS_MAX)) q = 128'(ROOT_POS_MAX);
        return 40'(q);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            bitv = r | (64'd1 << i);
            if (bitv * bitv <= v) r = bitv;
        end
        return r;
    endfunction

    function automatic t_roots solve_roots(t_coefs s);
        t_roots r;
        longint a;
        longint b;
        longint c;
        longint disc;
        longint sq;
        a = longint'($signed(s.a));
        b = longint'($signed(s.b));
        c = longint'($signed(s.c));
        r = '{ST_NOT_QUAD, 40'd0, 40'd0};
        if (a == 0) return r;
        disc = b*b - 4*a*c;     // fits easily in 64 bits for 16-bit coefficients
        if (disc < 0) begin
            r.status = ST_NO_REAL;
        end else if (disc == 0) begin
            r.status = ST_SINGLE;
            r.plus   = fixed_div(-b, a);
        end else begin
            sq       = longint'(int_sqrt(64'(disc)));
            r.status = ST_TWO;
            r.plus   = fixed_div(-b + sq, a);
            r.minus  = fixed_div(-b - sq, a);
        end
        return r;
    endfunction

    function automatic t_coefs pick_set();
        t_coefs s;
        int     k;
        int     m;
        k = int'($urandom_range(0, 9));
        s.a = 16'($urandom);
        s.b = 16'($urandom);
        s.c = 16'($urandom);
        case (k)
            0: s.a = 16'd0;
            1: begin
                // perfect square trinomial: single root
                m   = int'($urandom_range(1, 180));
                s.a = 16'($urandom_range(0, 1) ? m : -m);
                s.c = 16'($urandom_range(0, 1) ? m : -m);
                if (($signed(s.a) < 0) != ($signed(s.c) < 0)) s.c = -s.c;
                s.b = 16'(2 * m * ($urandom_range(0, 1) ? 1 : -1));
            end
            2: begin
                s.a = 16'($signed(16'($urandom_range(0, 30))) - 15);
                s.c = 16'($signed(16'($urandom_range(0, 30))) - 15);
            end
            3: s.a = 16'($urandom_range(0, 1) ? 16'h8000 : 16'h7fff);
            default: ;
        endcase
        return s;
    endfunction

    // driver: offer the next pending set, idling at random outside calm stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (i_s_tvalid) n_sent <= n_sent + 1;
            if (pending_sets.size() > 0 && (calm || $urandom_range(0, 99) >= 29)) begin
                i_s_tdata  <= IN_W'({pending_sets[0].c, pending_sets[0].b, pending_sets[0].a});
                i_s_tvalid <= 1'b1;
                expected_roots.push_back(solve_roots(pending_sets.pop_front()));
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compare every result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_roots exp_r;
        if (i_rst_n) begin
            if (hold_off && hold_cnt < 300) begin
                hold_cnt   <= hold_cnt + 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= calm || $urandom_range(0, 99) >= 29;
            end
            if (o_m_tvalid && i_m_tready) begin
                n_got <= n_got + 1;
                if (expected_roots.size() == 0) begin
                    $display("%0t unexpected result: actual status %0d data %h",
                             $time, o_m_tuser, o_m_tdata);
                    n_errors = n_errors + 1;
                end else begin
                    exp_r = expected_roots.pop_front();
                    status_seen[exp_r.status] <= status_seen[exp_r.status] + 1;
                    if (o_m_tuser !== exp_r.status) begin
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, exp_r.status, o_m_tuser);
                        n_errors = n_errors + 1;
                    end
                    if (o_m_tdata[39:0] !== exp_r.plus) begin
                        $display("%0t root_plus mismatch: expected %h actual %h",
                                 $time, exp_r.plus, o_m_tdata[39:0]);
                        n_errors = n_errors + 1;
                    end
                    if (o_m_tdata[79:40] !== exp_r.minus) begin
                        $display("%0t root_minus mismatch: expected %h actual %h",
                                 $time, exp_r.minus, o_m_tdata[79:40]);
                        n_errors = n_errors + 1;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [15:0] edges[5];
        t_coefs      s;
        edges = '{16'h8000, 16'hffff, 16'h0000, 16'h0001, 16'h7fff};
        // directed: extremes and each status
        foreach (edges[i]) pending_sets.push_back('{edges[i], edges[(i+2)%5], edges[(i+4)%5]});
        pending_sets.push_back('{16'h0000, 16'h1234, 16'h5678});   // not quadratic
        pending_sets.push_back('{16'd1, 16'd0, 16'd1});            // no real root
        pending_sets.push_back('{16'd1, -16'sd2, 16'd1});          // single root
        pending_sets.push_back('{-16'sd3, 16'd12, -16'sd12});      // single root, a negative
        pending_sets.push_back('{16'd1, 16'd0, -16'sd4});          // two roots
        pending_sets.push_back('{16'h8000, 16'h8000, 16'h7fff});   // widest discriminant
        pending_sets.push_back('{16'd1, 16'h8000, 16'h8000});
        pending_sets.push_back('{16'hffff, 16'h7fff, 16'h7fff});
        pending_sets.push_back('{16'haaaa, 16'h5555, 16'hffff});
        pending_sets.push_back('{16'h5555, 16'haaaa, 16'h0000});
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // calm stretch followed by a long receiver stall with the sender busy
        calm = 1'b1;
        for (int i = 0; i < 300; i++) pending_sets.push_back(pick_set());
        wait (pending_sets.size() < 150);
        calm = 1'b0;
        hold_off = 1'b1;
        for (int i = 0; i < N_RANDOM - 300; i++) begin
            s = pick_set();
            pending_sets.push_back(s);
        end
        wait (pending_sets.size() == 0 && !i_s_tvalid);
        wait (expected_roots.size() == 0);
        repeat (80) @(posedge i_clk);
        $display("sent %0d coefficient sets, checked %0d: %0d not quadratic, %0d no real root,",
                 n_sent, n_got, status_seen[0], status_seen[1]);
        $display("  %0d single root, %0d two roots, with random stalls and one long hold",
                 status_seen[2], status_seen[3]);
        if (n_errors == 0 && expected_roots.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### quadratic_root_solver.f
design/qrs_pkg.sv
design/qrs_isqrt.sv
design/qrs_div.sv
design/quadratic_root_solver.sv
tb/sv/quadratic_root_solver_tb.sv
